### sv/line_token_splitter_top_assert.svh
// Assertion macros for the token splitter.
// All checks are sampled on i_clk and held off while i_rst_n is low.
`ifndef LINE_TOKEN_SPLITTER_TOP_ASSERT_SVH
`define LINE_TOKEN_SPLITTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LTS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define LTS_ASSERT(lbl, prop, msg)
`define LTS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### sv/lts_pkg.sv
`default_nettype none
package lts_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2
    } t_kind;

    // result pattern of one item, in emit order
    typedef enum logic [2:0] {
        OP_CHAR         = 3'd0,
        OP_END          = 3'd1,
        OP_LINE         = 3'd2,
        OP_CHAR_END     = 3'd3,
        OP_END_LINE     = 3'd4,
        OP_END_CHAR_END = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [7:0] len;
        logic       ovf;
        logic       unt;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return (wide > 32'd255) ? 8'hFF : wide[7:0];
    endfunction

endpackage
`default_nettype wire

### sv/lts_front.sv
`default_nettype none
`include "line_token_splitter_top_assert.svh"
module lts_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_char,
    input  lts_pkg::t_qstat  i_stat,
    output logic             o_ready,
    output logic             o_push,
    output lts_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_PLAIN   = 2'd1,
        MODE_QUOTED  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_mode;

    t_mode                     r_mode,  n_mode;
    logic [lts_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_ovf,   n_ovf;
    logic                      w_emit;
    logic                      w_accept;
    logic                      w_space, w_special, w_eol, w_hash, w_quote, w_keep;

    assign o_ready  = !i_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && w_emit;

    assign w_space   = (i_char == lts_pkg::CH_SPACE) || (i_char == lts_pkg::CH_TAB);
    assign w_special = (i_char == lts_pkg::CH_LBRACE) || (i_char == lts_pkg::CH_RBRACE) ||
                       (i_char == lts_pkg::CH_SEMI)   || (i_char == lts_pkg::CH_EQUAL)  ||
                       (i_char == lts_pkg::CH_COMMA);
    assign w_eol     = (i_char == lts_pkg::CH_NL) || (i_char == lts_pkg::CH_NUL);
    assign w_hash    = (i_char == lts_pkg::CH_HASH);
    assign w_quote   = (i_char == lts_pkg::CH_QUOTE);
    assign w_keep    = r_count < lts_pkg::CNT_W'(lts_pkg::MAX_TOKEN_LEN);

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        n_ovf     = r_ovf;
        w_emit    = 1'b0;
        o_cmd.op  = lts_pkg::OP_CHAR;
        o_cmd.ch  = i_char;
        o_cmd.len = lts_pkg::sat_len(r_count);
        o_cmd.ovf = r_ovf;
        o_cmd.unt = 1'b0;
        unique case (r_mode)
            MODE_BETWEEN: begin
                if (w_space) begin
                end else if (w_special) begin
                    // one-char token, always kept
                    w_emit    = 1'b1;
                    o_cmd.op  = lts_pkg::OP_CHAR_END;
                end else if (w_quote) begin
                    n_mode = MODE_QUOTED;
                end else if (w_eol) begin
                    w_emit   = 1'b1;
                    o_cmd.op = lts_pkg::OP_LINE;
                end else if (w_hash) begin
                    w_emit   = 1'b1;
                    o_cmd.op = lts_pkg::OP_LINE;
                    n_mode   = MODE_COMMENT;
                end else begin
                    w_emit   = 1'b1;
                    o_cmd.op = lts_pkg::OP_CHAR;
                    n_count  = lts_pkg::CNT_W'(1);
                    n_mode   = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (w_space || w_special || w_eol || w_hash) begin
                    w_emit  = 1'b1;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_mode  = w_hash ? MODE_COMMENT : MODE_BETWEEN;
                    if (w_space)        o_cmd.op = lts_pkg::OP_END;
                    else if (w_special) o_cmd.op = lts_pkg::OP_END_CHAR_END;
                    else                o_cmd.op = lts_pkg::OP_END_LINE;
                end else if (w_keep) begin
                    w_emit  = 1'b1;
                    n_count = r_count + lts_pkg::CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            MODE_QUOTED: begin
                if (w_quote || w_eol) begin
                    w_emit    = 1'b1;
                    n_count   = '0;
                    n_ovf     = 1'b0;
                    n_mode    = MODE_BETWEEN;
                    o_cmd.op  = w_quote ? lts_pkg::OP_END : lts_pkg::OP_END_LINE;
                    o_cmd.unt = w_eol;
                end else if (w_keep) begin
                    w_emit  = 1'b1;
                    n_count = r_count + lts_pkg::CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (w_eol) begin
                    n_mode = MODE_BETWEEN;
                end
            end
            default: begin
                n_mode = MODE_BETWEEN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BETWEEN;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    `LTS_ASSERT(a_idle_clear, ((r_mode == MODE_BETWEEN) || (r_mode == MODE_COMMENT)) |-> ((r_count == '0) && !r_ovf), "count or overflow left set outside a token")
    `LTS_ASSERT(a_cnt_range, (32'(r_count) <= 32'(lts_pkg::MAX_TOKEN_LEN)), "token count beyond maximum")
    `LTS_ASSERT(a_ovf_full, r_ovf |-> (32'(r_count) == 32'(lts_pkg::MAX_TOKEN_LEN)), "overflow flagged before token was full")

endmodule
`default_nettype wire

### sv/lts_fifo.sv
`default_nettype none
`include "line_token_splitter_top_assert.svh"
module lts_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lts_pkg::t_cmd    i_cmd,
    input  wire              i_pop,
    output lts_pkg::t_cmd    o_head,
    output lts_pkg::t_qstat  o_stat
);

    lts_pkg::t_cmd              r_mem [lts_pkg::QUEUE_DEPTH];
    logic [lts_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [lts_pkg::QCNT_W-1:0] r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == lts_pkg::QCNT_W'(lts_pkg::QUEUE_DEPTH);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == lts_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (32'(r_rd) == lts_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `LTS_ASSERT_NEVER(a_push_full, (i_push && o_stat.full), "push into full queue")
    `LTS_ASSERT_NEVER(a_pop_empty, (i_pop && o_stat.empty), "pop from empty queue")
    `LTS_ASSERT(a_ptr_gap, (r_cnt == '0) |-> (r_wr == r_rd), "pointers apart with queue empty")

endmodule
`default_nettype wire

### sv/lts_back.sv
`default_nettype none
`include "line_token_splitter_top_assert.svh"
module lts_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  lts_pkg::t_cmd                     i_head,
    input  lts_pkg::t_qstat                   i_stat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [lts_pkg::OUT_TDATA_W-1:0]   o_data,
    output logic [1:0]                        o_user,
    output logic                              o_last
);

    logic [1:0]     r_step;
    logic           r_valid;
    lts_pkg::t_kind r_kind;
    logic [7:0]     r_ch;
    logic [7:0]     r_len;
    logic           r_ovf;
    logic           r_unt;
    logic           r_last;

    lts_pkg::t_kind n_kind;
    logic [7:0]     n_ch;
    logic [7:0]     n_len;
    logic           n_ovf;
    logic           n_unt;
    logic           n_last;
    logic           w_adv;
    logic           w_take;

    assign w_adv  = !r_valid || i_ready;
    assign w_take = w_adv && !i_stat.empty;
    assign o_pop  = w_take && n_last;

    // expand the head item one result per cycle while the output is not stalled
    always_comb begin
        n_kind = lts_pkg::KIND_END;
        n_ch   = 8'd0;
        n_len  = i_head.len;
        n_ovf  = i_head.ovf;
        n_unt  = i_head.unt;
        n_last = 1'b1;
        unique case (i_head.op)
            lts_pkg::OP_CHAR: begin
                n_kind = lts_pkg::KIND_CHAR;
            end
            lts_pkg::OP_END: begin
                n_kind = lts_pkg::KIND_END;
            end
            lts_pkg::OP_LINE: begin
                n_kind = lts_pkg::KIND_LINE;
            end
            lts_pkg::OP_CHAR_END: begin
                n_kind = (r_step == 2'd0) ? lts_pkg::KIND_CHAR : lts_pkg::KIND_END;
                n_len  = 8'd1;
                n_ovf  = 1'b0;
                n_last = r_step != 2'd0;
            end
            lts_pkg::OP_END_LINE: begin
                n_kind = (r_step == 2'd0) ? lts_pkg::KIND_END : lts_pkg::KIND_LINE;
                n_last = r_step != 2'd0;
            end
            lts_pkg::OP_END_CHAR_END: begin
                n_kind = (r_step == 2'd1) ? lts_pkg::KIND_CHAR : lts_pkg::KIND_END;
                n_last = r_step == 2'd2;
                if (r_step == 2'd2) begin
                    n_len = 8'd1;
                    n_ovf = 1'b0;
                end
            end
            default: begin
                n_kind = lts_pkg::KIND_LINE;
            end
        endcase
        if (n_kind == lts_pkg::KIND_CHAR) begin
            n_ch = i_head.ch;
        end
        if (n_kind != lts_pkg::KIND_END) begin
            n_len = 8'd0;
            n_ovf = 1'b0;
            n_unt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 2'd0;
        end else if (w_adv) begin
            r_valid <= !i_stat.empty;
            if (w_take) begin
                r_step <= n_last ? 2'd0 : r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_kind <= n_kind;
            r_ch   <= n_ch;
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_unt  <= n_unt;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_user  = r_kind;
    assign o_data  = {6'd0, r_unt, r_ovf, r_len, r_ch};

    `LTS_ASSERT(a_mid_item, (r_step != 2'd0) |-> !i_stat.empty, "item popped too early")
    `LTS_ASSERT_NEVER(a_step_range, (r_step == 2'd3), "result step out of range")
    `LTS_ASSERT(a_line_last, (r_valid && (r_kind == lts_pkg::KIND_LINE)) |-> r_last, "line end not last")

endmodule
`default_nettype wire

### sv/line_token_splitter_top.sv
`default_nettype none
// channel   dir  tdata                                   tuser       tlast
// s_axis    in   [7:0] char_in                           -           -
// m_axis    out  [7:0] char_out, [15:8] token_length,    [1:0] kind  last
//                [16] overflowed, [17] unterminated,
//                [23:18] zero
//
// One character is taken each cycle while the four-entry item queue has room.
// Items give one to three results; the back end sends one result per cycle unless m_axis
// is stalled, so the rate is one item per cycle when results average at most one per item.
// Synchronous active-low reset returns the scanner to between tokens and empties the queue.
// A stalled m_axis fills the queue; s_axis tready drops only when it is full.
module line_token_splitter_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [7:0]                       s_axis_tdata,   // [7:0] char_in
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [lts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // char_out, token_length,
                                                             // overflowed, unterminated
    output logic [1:0]                       m_axis_tuser,   // [1:0] kind
    output logic                             m_axis_tlast
);

    lts_pkg::t_qstat w_stat;
    lts_pkg::t_cmd   w_cmd;
    lts_pkg::t_cmd   w_head;
    logic            w_push;
    logic            w_pop;

    lts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_stat  (w_stat),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    lts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    lts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
